// ----- rtl/device_address_table_macros.svh -----
// ---------------------------------------------------------------------------
// Device address table assertion macros
// Shared concurrent assertion forms, clocked on clk_i and reset by rst_ni.
// ---------------------------------------------------------------------------
`ifndef DEVICE_ADDRESS_TABLE_MACROS_SVH
`define DEVICE_ADDRESS_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
`define DAT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("device address table assertion failed");
`define DAT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("device address table assertion failed");
`else
`define DAT_ASSERT(lbl, prop)
`define DAT_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ----- rtl/dat_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Device address table package
// Word types, search token, commit command and status codes.
// ---------------------------------------------------------------------------
package dat_pkg;

  localparam logic [15:0] FamilyReset = 16'h02FF;

  localparam logic [1:0] ReqAdd    = 2'd0;
  localparam logic [1:0] ReqRemove = 2'd1;
  localparam logic [1:0] ReqFetch  = 2'd2;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StPresent  = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [47:0] device_address;
    logic [63:0] ident_high;
    logic [63:0] ident_low;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  device_count;
    logic [47:0] found_address;
    logic [63:0] found_ident_high;
    logic [63:0] found_ident_low;
  } rsp_t;

  typedef struct packed {
    logic        active;
    logic [47:0] addr;
    logic        match;
    logic        free;
    logic        fam;
    logic [47:0] fam_addr;
    logic [63:0] fam_ih;
    logic [63:0] fam_il;
  } token_t;

  typedef struct packed {
    logic        ins;
    logic        rem;
    logic        family;
    logic [47:0] addr;
    logic [63:0] ih;
    logic [63:0] il;
  } cmd_t;

endpackage

// ----- rtl/dat_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Device address table cell
// Holds one entry, updates the passing search token and applies commits.
// ---------------------------------------------------------------------------
module dat_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dat_pkg::token_t tok_i,
  input  dat_pkg::cmd_t   cmd_i,
  output dat_pkg::token_t tok_o
);
  import dat_pkg::*;

  logic        valid_q;
  logic        family_q;
  logic [47:0] addr_q;
  logic [63:0] ih_q;
  logic [63:0] il_q;
  logic        hit_q, hit_d;
  logic        ins_q, ins_d;
  logic        fam_here;
  token_t      tok_q, tok_d;

  always_comb begin
    hit_d    = tok_i.active && valid_q && (addr_q == tok_i.addr) && !tok_i.match;
    ins_d    = tok_i.active && !valid_q && !tok_i.free;
    fam_here = tok_i.active && valid_q && family_q && !tok_i.fam;
    tok_d       = tok_i;
    tok_d.match = tok_i.match || (valid_q && (addr_q == tok_i.addr));
    tok_d.free  = tok_i.free || !valid_q;
    tok_d.fam   = tok_i.fam || (valid_q && family_q);
    if (fam_here) begin
      tok_d.fam_addr = addr_q;
      tok_d.fam_ih   = ih_q;
      tok_d.fam_il   = il_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      family_q <= 1'b0;
      hit_q    <= 1'b0;
      ins_q    <= 1'b0;
      tok_q    <= '0;
    end else begin
      tok_q <= tok_d;
      if (tok_i.active) begin
        hit_q <= hit_d;
        ins_q <= ins_d;
      end
      if (cmd_i.ins && ins_q) begin
        valid_q  <= 1'b1;
        family_q <= cmd_i.family;
      end else if (cmd_i.rem && hit_q) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins && ins_q) begin
      addr_q <= cmd_i.addr;
      ih_q   <= cmd_i.ih;
      il_q   <= cmd_i.il;
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- rtl/device_address_table.sv -----
// A request word is accepted only while idle. Its search token passes through the
// token register of every cell and into the hold register; the commit state then
// offers the result when the output slot is free; only then is a new word taken.
// Reset clears every valid and family mark, the device count and both handshakes
// at once, and returns family_code to 0x02FF; no clearing pass is needed.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Device address table
// Chain of entry cells searched by a travelling token, with APB configuration.
// ---------------------------------------------------------------------------
module device_address_table #(
  parameter int TABLE_ENTRIES = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dat_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dat_pkg::rsp_t out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import dat_pkg::*;

  `include "device_address_table_macros.svh"

  localparam int CntW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  state_e            state_q;
  req_t              req_q;
  token_t            hold_q;
  rsp_t              out_data_q, rsp_d;
  logic              out_valid_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW+4:0]   cnt_ext;
  logic [15:0]       family_q;
  logic              accept, slot_free, fin_go, ins_c, rem_c;
  cmd_t              cmd;
  token_t            tok_head;
  token_t            tok [TABLE_ENTRIES+1];

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign slot_free  = !out_valid_q || out_ready_i;
  assign fin_go     = (state_q == ST_FIN) && slot_free;

  always_comb begin
    tok_head        = '0;
    tok_head.active = accept;
    tok_head.addr   = in_data_i.device_address;
  end

  assign tok[0] = tok_head;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    dat_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok[g]),
      .cmd_i (cmd),
      .tok_o (tok[g+1])
    );
  end

  always_comb begin
    rsp_d  = '0;
    ins_c  = 1'b0;
    rem_c  = 1'b0;
    cnt_d  = cnt_q;
    rsp_d.status = StNotFound;
    case (req_q.req_type)
      ReqAdd: begin
        if (hold_q.match) begin
          rsp_d.status = StPresent;
        end else if (hold_q.free) begin
          rsp_d.status = StOk;
          ins_c        = 1'b1;
          cnt_d        = cnt_q + CntW'(1);
        end else begin
          rsp_d.status = StFull;
        end
      end
      ReqRemove: begin
        if (hold_q.match) begin
          rsp_d.status = StOk;
          rem_c        = 1'b1;
          if (cnt_q != '0) begin
            cnt_d = cnt_q - CntW'(1);
          end
        end
      end
      ReqFetch: begin
        if (hold_q.fam) begin
          rsp_d.status           = StOk;
          rsp_d.found_address    = hold_q.fam_addr;
          rsp_d.found_ident_high = hold_q.fam_ih;
          rsp_d.found_ident_low  = hold_q.fam_il;
        end
      end
      default: begin
        rsp_d.status = StNotFound;
      end
    endcase
    cnt_ext            = {5'd0, cnt_d};
    rsp_d.device_count = cnt_ext[4:0];
  end

  always_comb begin
    cmd        = '0;
    cmd.ins    = fin_go && ins_c;
    cmd.rem    = fin_go && rem_c;
    cmd.family = (req_q.ident_high[63:48] == family_q);
    cmd.addr   = req_q.device_address;
    cmd.ih     = req_q.ident_high;
    cmd.il     = req_q.ident_low;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      req_q       <= '0;
      hold_q      <= '0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !fin_go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            req_q   <= in_data_i;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tok[TABLE_ENTRIES].active) begin
            hold_q  <= tok[TABLE_ENTRIES];
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            out_data_q  <= rsp_d;
            out_valid_q <= 1'b1;
            cnt_q       <= cnt_d;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      family_q <= FamilyReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      family_q <= pwdata[15:0];
    end
  end

  assign prdata      = paddr[2] ? 32'd0 : {16'd0, family_q};
  assign pready      = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `DAT_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready_o)
  `DAT_ASSERT(a_tail_only_in_scan, !tok[TABLE_ENTRIES].active || (state_q == ST_SCAN))
  `DAT_ASSERT(a_count_bounded, cnt_q <= CntW'(TABLE_ENTRIES))
  `DAT_ASSERT(a_result_after_fin, !$rose(out_valid_q) || $past(state_q == ST_FIN))

endmodule

// ----- sim/device_address_table_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Device address table checker
// Watches the request, response and configuration ports, keeps its own copy
// of the table and the family code, works out the response to every accepted
// request word and compares each response word field by field in order.
// ---------------------------------------------------------------------------
module device_address_table_checker #(
  parameter int         Entries    = 24,
  parameter logic [2:0] FamilyAddr = 3'd0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  dat_pkg::req_t in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  dat_pkg::rsp_t out_data_i,
  input  logic          psel_i,
  input  logic          penable_i,
  input  logic          pwrite_i,
  input  logic          pready_i,
  input  logic [2:0]    paddr_i,
  input  logic [31:0]   pwdata_i,
  output int            pending_o,
  output int            fail_count_o
);
  import dat_pkg::*;

  logic        slot_valid [Entries];
  logic        slot_family[Entries];
  logic [47:0] slot_addr  [Entries];
  logic [63:0] slot_ih    [Entries];
  logic [63:0] slot_il    [Entries];
  logic [4:0]  live_devices;
  logic [15:0] family_code;
  rsp_t        awaited_rsp_q[$];
  int          awaiting = 0;
  int          fails = 0;

  assign pending_o    = awaiting;
  assign fail_count_o = fails;

  function automatic int find_slot(logic [47:0] addr);
    for (int i = 0; i < Entries; i++) begin
      if (slot_valid[i] && slot_addr[i] == addr) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic rsp_t apply_request(req_t w);
    rsp_t r;
    int   hit;
    r        = '0;
    r.status = StNotFound;
    hit      = -1;
    case (w.req_type)
      ReqAdd: begin
        if (find_slot(w.device_address) >= 0) begin
          r.status = StPresent;
        end else begin
          r.status = StFull;
          for (int i = Entries - 1; i >= 0; i--) begin
            if (!slot_valid[i]) begin
              hit = i;
            end
          end
          if (hit >= 0) begin
            slot_valid[hit]  = 1'b1;
            slot_addr[hit]   = w.device_address;
            slot_ih[hit]     = w.ident_high;
            slot_il[hit]     = w.ident_low;
            slot_family[hit] = (w.ident_high[63:48] == family_code);
            live_devices     = live_devices + 5'd1;
            r.status         = StOk;
          end
        end
      end
      ReqRemove: begin
        hit = find_slot(w.device_address);
        if (hit >= 0) begin
          slot_valid[hit] = 1'b0;
          if (live_devices != 5'd0) begin
            live_devices = live_devices - 5'd1;
          end
          r.status = StOk;
        end
      end
      ReqFetch: begin
        for (int i = Entries - 1; i >= 0; i--) begin
          if (slot_valid[i] && slot_family[i]) begin
            hit = i;
          end
        end
        if (hit >= 0) begin
          r.found_address    = slot_addr[hit];
          r.found_ident_high = slot_ih[hit];
          r.found_ident_low  = slot_il[hit];
          r.status           = StOk;
        end
      end
      default: begin
      end
    endcase
    r.device_count = live_devices;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) begin
        slot_valid[i]  = 1'b0;
        slot_family[i] = 1'b0;
      end
      live_devices = '0;
      family_code  = FamilyReset;
      awaited_rsp_q.delete();
      awaiting = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[2] == FamilyAddr[2]) begin
        family_code = pwdata_i[15:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_rsp_q.size() == 0) begin
          fails++;
          $display("%0t: response word %h arrived with none expected", $time, out_data_i);
        end else begin
          want = awaited_rsp_q.pop_front();
          check_field("status", 64'(want.status), 64'(out_data_i.status));
          check_field("device_count", 64'(want.device_count),
                      64'(out_data_i.device_count));
          check_field("found_address", 64'(want.found_address),
                      64'(out_data_i.found_address));
          check_field("found_ident_high", want.found_ident_high,
                      out_data_i.found_ident_high);
          check_field("found_ident_low", want.found_ident_low,
                      out_data_i.found_ident_low);
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_rsp_q.push_back(apply_request(in_data_i));
      end
      awaiting = awaited_rsp_q.size();
    end
  end

endmodule

// ----- sim/device_address_table_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Device address table testbench
// Drives request words and family code writes into the table, with random
// gaps on the request side and random stalls on the response side, and
// reports the verdict counted by the checker beside the block.
// ---------------------------------------------------------------------------
module device_address_table_tb;
  import dat_pkg::*;

  localparam int         TableEntries   = 24;
  localparam logic [2:0] FamilyCodeAddr = 3'd0;
  localparam logic [1:0] ReqUnused      = 2'd3;
  localparam int         Phases         = 5;
  localparam int         WordsPerPhase  = 380;
  localparam int         CycleLimit     = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  req_t        in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  rsp_t        out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          pending;
  int          fail_count;
  int          cycles = 0;
  int          ready_hold = 0;
  int          gap_pct = 0;
  bit          ready_steady = 1'b0;
  logic [15:0] family_now = FamilyReset;
  logic [47:0] addr_pool[$];
  logic [15:0] phase_codes[Phases];

  device_address_table #(
    .TABLE_ENTRIES(TableEntries)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  device_address_table_checker #(
    .Entries   (TableEntries),
    .FamilyAddr(FamilyCodeAddr)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("device_address_table: mismatch");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (ready_steady) begin
      out_ready_i <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_ready_i <= 1'b0;
      ready_hold  = $urandom_range(1, 15) - 1;
    end else begin
      out_ready_i <= 1'b1;
      ready_hold  = $urandom_range(1, 60) - 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = rand64();
    return v[47:0];
  endfunction

  function automatic req_t make_word(logic [1:0] kind, logic [47:0] addr,
                                     logic [63:0] ih, logic [63:0] il);
    req_t w;
    w.req_type       = kind;
    w.device_address = addr;
    w.ident_high     = ih;
    w.ident_low      = il;
    return w;
  endfunction

  task automatic send_word(req_t w);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
  endtask

  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_family(logic [15:0] code);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FamilyCodeAddr;
    pwdata  <= {16'h0000, code};
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    family_now = code;
  endtask

  task automatic run_directed();
    send_word(make_word(ReqFetch, '0, '0, '0));
    send_word(make_word(ReqUnused, '1, '1, '1));
    send_word(make_word(ReqRemove, '0, '0, '0));
    send_word(make_word(ReqAdd, '0, {FamilyReset, 48'h0}, '0));
    send_word(make_word(ReqAdd, '1, '1, '1));
    send_word(make_word(ReqAdd, '0, '1, '1));
    send_word(make_word(ReqFetch, '1, '0, '0));
    send_word(make_word(ReqRemove, '0, '0, '0));
    send_word(make_word(ReqFetch, '0, '0, '0));
    send_word(make_word(ReqAdd, 48'h1234_5678_9ABC, 64'h0200_FFFF_0000_FFFF,
                        64'hA5A5_5A5A_0F0F_F0F0));
    send_word(make_word(ReqFetch, '0, '0, '0));
    send_word(make_word(ReqAdd, 48'hAAAA_AAAA_AAAA, 64'h02FF_5555_AAAA_5555,
                        64'h5555_AAAA_5555_AAAA));
    send_word(make_word(ReqAdd, 48'h5555_5555_5555, 64'hFF02_0000_0000_0000, '0));
    send_word(make_word(ReqFetch, '0, '0, '0));
    send_word(make_word(ReqRemove, 48'hAAAA_AAAA_AAAA, '0, '0));
    send_word(make_word(ReqFetch, '0, '0, '0));
    send_word(make_word(ReqRemove, '1, '0, '0));
    send_word(make_word(ReqRemove, 48'h1234_5678_9ABC, '0, '0));
    send_word(make_word(ReqRemove, 48'h5555_5555_5555, '0, '0));
    send_word(make_word(ReqFetch, '0, '0, '0));
  endtask

  task automatic run_phase(int words, int add_pct, bit pause_midway);
    logic [1:0]  kind;
    logic [47:0] addr;
    logic [63:0] ih;
    int          pick;
    for (int n = 0; n < words; n++) begin
      if (pause_midway && n == words / 2) begin
        drain();
      end
      if ($urandom_range(0, 99) < gap_pct) begin
        hold_off($urandom_range(1, 15));
      end
      pick = $urandom_range(0, 99);
      if (pick < add_pct) begin
        kind = ReqAdd;
      end else if (pick < add_pct + 25) begin
        kind = ReqRemove;
      end else if (pick < 96) begin
        kind = ReqFetch;
      end else begin
        kind = ReqUnused;
      end
      addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
      if (kind != ReqAdd && $urandom_range(0, 9) == 0) begin
        addr = rand48();
      end
      ih = rand64();
      if ($urandom_range(0, 1) == 0) begin
        ih[63:48] = family_now;
      end
      send_word(make_word(kind, addr, ih, rand64()));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_family(FamilyReset);
    run_directed();

    repeat ($urandom_range(30, 44)) begin
      addr_pool.push_back(rand48());
    end
    phase_codes[0] = 16'h0000;
    phase_codes[1] = 16'hFFFF;
    phase_codes[2] = 16'($urandom);
    phase_codes[3] = FamilyReset;
    phase_codes[4] = 16'($urandom);

    for (int p = 0; p < Phases; p++) begin
      drain();
      write_family(phase_codes[p]);
      if (p == Phases - 1) begin
        gap_pct      = 0;
        ready_steady = 1'b1;
      end else begin
        gap_pct = $urandom_range(0, 40);
      end
      run_phase(WordsPerPhase, (p % 2 == 1) ? 60 : 45, p == 1);
    end

    drain();
    repeat (TableEntries + 4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("device_address_table: match");
    end else begin
      $display("device_address_table: mismatch");
    end
    $finish;
  end

endmodule

// ----- device_address_table.f -----
+incdir+rtl
rtl/dat_pkg.sv
rtl/dat_cell.sv
rtl/device_address_table.sv
sim/device_address_table_checker.sv
sim/device_address_table_tb.sv
